/* design/aes_cbc_block_cipher_assert.svh */
// Assertion macros for the CBC cipher block
`ifndef AES_CBC_BLOCK_CIPHER_ASSERT_SVH
`define AES_CBC_BLOCK_CIPHER_ASSERT_SVH
`ifndef ASSERT_OFF
// checked outside reset only
`define CBC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked on every edge, reset included
`define CBC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CBC_ASSERT(lbl, prop, msg)
`define CBC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* design/aescbc_pkg.sv */
`default_nettype none
package aescbc_pkg;

	typedef logic [0:255][7:0] sbox_tbl_t;

	localparam sbox_tbl_t SBOX = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	// inverse table, built at elaboration from the forward one
	function automatic sbox_tbl_t build_inv();
		sbox_tbl_t t;
		for (int i = 0; i < 256; i++) begin
			t[SBOX[i]] = 8'(i);
		end
		return t;
	endfunction

	localparam sbox_tbl_t INV_SBOX = build_inv();

	// register indexes
	localparam logic [2:0] REG_KEY_SIZE = 3'd0;
	localparam logic [2:0] REG_KEY_W0   = 3'd1;
	localparam logic [2:0] REG_KEY_W1   = 3'd2;
	localparam logic [2:0] REG_KEY_W2   = 3'd3;
	localparam logic [2:0] REG_KEY_W3   = 3'd4;
	localparam logic [2:0] REG_IV_HIGH  = 3'd5;
	localparam logic [2:0] REG_IV_LOW   = 3'd6;

	localparam logic MODE_ENC = 1'b0;
	localparam logic MODE_DEC = 1'b1;

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] byte_of(input logic [127:0] s, input int i);
		return s[127 - 8*i -: 8];
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	// SubBytes then ShiftRows
	function automatic logic [127:0] fwd_sub_shift(input logic [127:0] s);
		logic [127:0] o;
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				o[127 - 8*(r + 4*c) -: 8] = SBOX[byte_of(s, r + 4*((c + r) % 4))];
			end
		end
		return o;
	endfunction

	// InvShiftRows then InvSubBytes
	function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
		logic [127:0] o;
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				o[127 - 8*(r + 4*((c + r) % 4)) -: 8] = INV_SBOX[byte_of(s, r + 4*c)];
			end
		end
		return o;
	endfunction

	function automatic logic [127:0] mix_cols(input logic [127:0] s, input logic inv);
		logic [127:0] o;
		logic [7:0] a [4];
		logic [7:0] x2 [4];
		logic [7:0] x4 [4];
		logic [7:0] x8 [4];
		logic [7:0] m1 [4];
		logic [7:0] m2 [4];
		logic [7:0] m3 [4];
		logic [7:0] m4 [4];
		for (int c = 0; c < 4; c++) begin
			for (int k = 0; k < 4; k++) begin
				a[k]  = byte_of(s, 4*c + k);
				x2[k] = xtime(a[k]);
				x4[k] = xtime(x2[k]);
				x8[k] = xtime(x4[k]);
				// coefficient per offset: fwd 2,3,1,1  inv 14,11,13,9
				m1[k] = inv ? (x8[k] ^ x4[k] ^ x2[k]) : x2[k];
				m2[k] = inv ? (x8[k] ^ x2[k] ^ a[k]) : (x2[k] ^ a[k]);
				m3[k] = inv ? (x8[k] ^ x4[k] ^ a[k]) : a[k];
				m4[k] = inv ? (x8[k] ^ a[k]) : a[k];
			end
			for (int r = 0; r < 4; r++) begin
				o[127 - 8*(4*c + r) -: 8] = m1[r] ^ m2[(r + 1) % 4]
					^ m3[(r + 2) % 4] ^ m4[(r + 3) % 4];
			end
		end
		return o;
	endfunction

endpackage
`default_nettype wire

/* design/aescbc_if.sv */
`default_nettype none
// input channel: one block and its mode per beat
interface aescbc_in_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [63:0] block_high;
	logic [63:0] block_low;
	modport source (output valid, mode, block_high, block_low, input ready);
	modport sink (input valid, mode, block_high, block_low, output ready);
endinterface

// result channel: one block per beat
interface aescbc_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] out_high;
	logic [63:0] out_low;
	modport source (output valid, out_high, out_low, input ready);
	modport sink (input valid, out_high, out_low, output ready);
endinterface
`default_nettype wire

/* design/aes_cbc_block_cipher.sv */
`default_nettype none
// AES-CBC cipher, one 128-bit block per beat, encrypt or decrypt chosen per beat.
// A shared round unit runs one AES round per clock. The input is ready again
// as the result is registered, so a new block is taken only after the last
// one is through; a result still waiting on the output holds the block in its
// last cycle. The chaining value makes each block wait for the previous one.
// The round keys live in a 15-row key RAM that is filled one 32-bit schedule
// word per clock after reset and after any write of the key size or key
// registers; no block is taken while it fills. Writes of either IV register
// reload the chaining value from both IV registers.
`include "aes_cbc_block_cipher_assert.svh"
module aes_cbc_block_cipher (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	aescbc_in_if.sink        din,
	aescbc_out_if.source     dout
);
	import aescbc_pkg::*;

	localparam logic [2:0] ST_EXP   = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_LOAD  = 3'd2;
	localparam logic [2:0] ST_ROUND = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	logic [2:0]   state_q;
	logic [1:0]   key_size_q;
	logic [255:0] key_q;
	logic [63:0]  iv_high_q, iv_low_q;
	logic [127:0] chain_q;

	// key schedule sequencer
	logic [5:0]   wi_q;
	logic [2:0]   kc_q;
	logic [7:0]   rcon_q;
	logic [31:0]  win_q [8];
	logic [95:0]  row_q;
	logic [127:0] rk_mem [15];

	// round datapath
	logic [127:0] rk_q;
	logic [3:0]   idx_q;
	logic [3:0]   rd_addr;
	logic [127:0] blk_q;
	logic [127:0] s_q;
	logic         mode_q;
	logic         out_valid_q;
	logic [127:0] out_q;

	logic [3:0]   nr;
	logic [3:0]   nk;
	logic [5:0]   last_wi;
	logic [31:0]  prev_w, far_w, new_w;
	logic         key_wr;
	logic         accept;
	logic         slot_free;
	logic         last_round;
	logic [127:0] round_out;

	// key length decode, size three treated as 256 bits
	always_comb begin
		unique case (key_size_q)
			2'd0:    begin nr = 4'd10; nk = 4'd4; end
			2'd1:    begin nr = 4'd12; nk = 4'd6; end
			default: begin nr = 4'd14; nk = 4'd8; end
		endcase
	end
	assign last_wi = 6'({nr, 2'b11});

	assign key_wr = cfg_wr_en && (cfg_index == REG_KEY_SIZE || cfg_index == REG_KEY_W0
		|| cfg_index == REG_KEY_W1 || cfg_index == REG_KEY_W2 || cfg_index == REG_KEY_W3);

	// next schedule word
	always_comb begin
		prev_w = win_q[0];
		far_w  = win_q[nk[2:0] - 3'd1];
		if (wi_q < 6'(nk)) begin
			new_w = key_q[255 - 32*wi_q[2:0] -: 32];
		end else if (kc_q == 3'd0) begin
			new_w = far_w ^ sub_word({prev_w[23:0], prev_w[31:24]}) ^ {rcon_q, 24'h0};
		end else if (nk == 4'd8 && kc_q == 3'd4) begin
			new_w = far_w ^ sub_word(prev_w);
		end else begin
			new_w = far_w ^ prev_w;
		end
	end

	assign accept     = din.valid && din.ready;
	assign din.ready  = (state_q == ST_IDLE);
	assign slot_free  = !out_valid_q || dout.ready;
	assign last_round = (mode_q == MODE_DEC) ? (idx_q == 4'd0) : (idx_q == nr);

	// one round of the shared unit
	always_comb begin
		if (mode_q == MODE_DEC) begin
			round_out = inv_shift_sub(s_q) ^ rk_q;
			if (!last_round) begin
				round_out = mix_cols(round_out, 1'b1);
			end
		end else begin
			round_out = fwd_sub_shift(s_q);
			if (!last_round) begin
				round_out = mix_cols(round_out, 1'b0);
			end
			round_out = round_out ^ rk_q;
		end
	end

	// key RAM read address: first key on accept, then stepping
	always_comb begin
		if (state_q == ST_IDLE) begin
			rd_addr = (din.mode == MODE_DEC) ? nr : 4'd0;
		end else if (mode_q == MODE_DEC) begin
			rd_addr = idx_q - 4'd1;
		end else begin
			rd_addr = idx_q + 4'd1;
		end
	end

	// key RAM
	always_ff @(posedge clk) begin
		if (state_q == ST_EXP && wi_q[1:0] == 2'b11) begin
			rk_mem[wi_q[5:2]] <= {row_q, new_w};
		end
		rk_q <= rk_mem[rd_addr];
	end

	// schedule payload
	always_ff @(posedge clk) begin
		if (state_q == ST_EXP) begin
			row_q <= {row_q[63:0], new_w};
			win_q[0] <= new_w;
			for (int k = 1; k < 8; k++) begin
				win_q[k] <= win_q[k-1];
			end
		end
	end

	// configuration registers and chaining value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_size_q <= 2'd0;
			key_q      <= '0;
			iv_high_q  <= '0;
			iv_low_q   <= '0;
			chain_q    <= '0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_KEY_SIZE: key_size_q <= cfg_data[1:0];
					REG_KEY_W0:   key_q[255:192] <= cfg_data;
					REG_KEY_W1:   key_q[191:128] <= cfg_data;
					REG_KEY_W2:   key_q[127:64] <= cfg_data;
					REG_KEY_W3:   key_q[63:0] <= cfg_data;
					REG_IV_HIGH: begin
						iv_high_q <= cfg_data;
						chain_q   <= {cfg_data, iv_low_q};
					end
					REG_IV_LOW: begin
						iv_low_q <= cfg_data;
						chain_q  <= {iv_high_q, cfg_data};
					end
					default: ;
				endcase
			end else if (state_q == ST_FIN && slot_free) begin
				chain_q <= (mode_q == MODE_DEC) ? blk_q : s_q;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_EXP;
			wi_q        <= '0;
			kc_q        <= '0;
			rcon_q      <= 8'h01;
			idx_q       <= '0;
			mode_q      <= MODE_ENC;
			out_valid_q <= 1'b0;
		end else begin
			// result beat: set on finish, cleared once taken
			if (!key_wr && state_q == ST_FIN && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
			if (key_wr) begin
				state_q <= ST_EXP;
				wi_q    <= '0;
				kc_q    <= '0;
				rcon_q  <= 8'h01;
			end else begin
				unique case (state_q)
					ST_EXP: begin
						if (wi_q >= 6'(nk) && kc_q == 3'd0) begin
							rcon_q <= xtime(rcon_q);
						end
						kc_q <= (kc_q == nk[2:0] - 3'd1) ? 3'd0 : kc_q + 3'd1;
						wi_q <= wi_q + 6'd1;
						if (wi_q == last_wi) begin
							state_q <= ST_IDLE;
						end
					end
					ST_IDLE: begin
						if (accept) begin
							mode_q  <= din.mode;
							idx_q   <= rd_addr;
							state_q <= ST_LOAD;
						end
					end
					ST_LOAD: begin
						idx_q   <= rd_addr;
						state_q <= ST_ROUND;
					end
					ST_ROUND: begin
						idx_q <= rd_addr;
						if (last_round) begin
							state_q <= ST_FIN;
						end
					end
					ST_FIN: begin
						if (slot_free) begin
							state_q <= ST_IDLE;
						end
					end
					default: state_q <= ST_EXP;
				endcase
			end
		end
	end

	// block payload
	always_ff @(posedge clk) begin
		if (accept) begin
			blk_q <= {din.block_high, din.block_low};
			s_q   <= (din.mode == MODE_DEC) ? {din.block_high, din.block_low}
				: ({din.block_high, din.block_low} ^ chain_q);
		end else if (state_q == ST_LOAD) begin
			s_q <= s_q ^ rk_q;
		end else if (state_q == ST_ROUND) begin
			s_q <= round_out;
		end
		if (state_q == ST_FIN && slot_free) begin
			out_q <= (mode_q == MODE_DEC) ? (s_q ^ chain_q) : s_q;
		end
	end

	assign dout.valid    = out_valid_q;
	assign dout.out_high = out_q[127:64];
	assign dout.out_low  = out_q[63:0];

	`CBC_ASSERT(a_accept_load, accept && !key_wr |=> state_q == ST_LOAD, "accept did not start a block")
	`CBC_ASSERT(a_idx_range, state_q == ST_ROUND |-> idx_q <= nr, "round key index past last round")
	`CBC_ASSERT(a_out_from_fin, $rose(out_valid_q) |-> $past(state_q == ST_FIN), "result without finish")
	`CBC_ASSERT(a_exp_range, state_q == ST_EXP |-> wi_q <= last_wi, "key schedule overran")
	`CBC_ASSERT_ALWAYS(a_rst_exp, !arst_n |-> state_q == ST_EXP, "reset did not restart schedule")

endmodule
`default_nettype wire
